// File: src/imu_afp_pkg.sv
// Shared types and constants for the IMU angle frame parser.
// Used by imu_afp_regs and imu_angle_frame_parser; depends on nothing else.
package imu_afp_pkg;

    // Register byte addresses on the configuration port.
    localparam logic [2:0] ADDR_HEADER = 3'd0;
    localparam logic [2:0] ADDR_TYPE   = 3'd4;

    localparam logic [7:0] HEADER_RESET = 8'h55;
    localparam logic [7:0] TYPE_RESET   = 8'h53;

    // Parse phase codes.
    localparam logic [1:0] PHASE_HUNT = 2'd0;
    localparam logic [1:0] PHASE_TYPE = 2'd1;
    localparam logic [1:0] PHASE_BODY = 2'd2;

    // Frame positions of the yaw bytes, counted from the header at zero.
    localparam int YAW_LO_POS = 6;
    localparam int YAW_HI_POS = 7;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] type_byte;
    } cfg_t;

endpackage

// File: src/imu_afp_regs.sv
// Configuration registers of the IMU angle frame parser, on an APB-style port.
// Depends on imu_afp_pkg.
module imu_afp_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output imu_afp_pkg::cfg_t  cfg
);

    imu_afp_pkg::cfg_t cfg_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // The two low address bits do not select anything; bit 2 picks the register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_byte <= imu_afp_pkg::HEADER_RESET;
            cfg_reg.type_byte   <= imu_afp_pkg::TYPE_RESET;
        end else if (wr_en) begin
            if (paddr[2] == imu_afp_pkg::ADDR_TYPE[2]) begin
                cfg_reg.type_byte <= pwdata[7:0];
            end else begin
                cfg_reg.header_byte <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == imu_afp_pkg::ADDR_TYPE[2]) begin
            prdata = {24'd0, cfg_reg.type_byte};
        end else begin
            prdata = {24'd0, cfg_reg.header_byte};
        end
    end

endmodule

// File: src/imu_angle_frame_parser.sv
// Top level of the IMU angle frame parser: byte framing, checksum and yaw output.
// Depends on imu_afp_pkg and imu_afp_regs.
//
// Takes one received byte per item, hunts for the header and type bytes, then
// collects a FRAME_LEN-byte frame. On the last byte it delivers one item with
// the raw yaw angle (frame bytes 6 and 7, LSB = 180/32768 degree) and a flag
// that is set when the last byte equals the 8-bit sum of all earlier bytes.
// A byte is taken in every cycle; the parser state updates in the same cycle
// and the result sits in a single output register. A frame's last byte is
// held off only while the previous result is still waiting to be taken.
module imu_angle_frame_parser #(
    parameter int FRAME_LEN = 11
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Byte input.
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    // Result output.
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_yaw_angle,
    output logic               m_checksum_ok
);

    localparam int IDX_W = $clog2(FRAME_LEN);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] YAW_LO   = IDX_W'(imu_afp_pkg::YAW_LO_POS);
    localparam logic [IDX_W-1:0] YAW_HI   = IDX_W'(imu_afp_pkg::YAW_HI_POS);

    imu_afp_pkg::cfg_t cfg;

    logic [1:0]       phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       yaw_lo_reg, yaw_lo_next;
    logic [7:0]       yaw_hi_reg, yaw_hi_next;
    logic             m_valid_reg, m_valid_next;
    logic [15:0]      yaw_out_reg, yaw_out_next;
    logic             ok_out_reg, ok_out_next;

    logic             s_fire;
    logic             frame_last;

    imu_afp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The next item completes a frame; this depends on state only.
    assign frame_last = (phase_reg == imu_afp_pkg::PHASE_BODY) && (idx_reg >= LAST_IDX);
    assign s_ready    = !(frame_last && m_valid_reg && !m_ready);
    assign s_fire     = s_valid && s_ready;

    assign m_valid       = m_valid_reg;
    assign m_yaw_angle   = yaw_out_reg;
    assign m_checksum_ok = ok_out_reg;

    always_comb begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        yaw_lo_next  = yaw_lo_reg;
        yaw_hi_next  = yaw_hi_reg;
        yaw_out_next = yaw_out_reg;
        ok_out_next  = ok_out_reg;
        m_valid_next = m_valid_reg && !m_ready;

        if (s_fire) begin
            case (phase_reg)
                imu_afp_pkg::PHASE_HUNT: begin
                    if (s_rx_byte == cfg.header_byte) begin
                        phase_next = imu_afp_pkg::PHASE_TYPE;
                        sum_next   = s_rx_byte;
                        idx_next   = IDX_W'(1);
                    end
                end
                imu_afp_pkg::PHASE_TYPE: begin
                    if (s_rx_byte == cfg.type_byte) begin
                        phase_next = imu_afp_pkg::PHASE_BODY;
                        sum_next   = sum_reg + s_rx_byte;
                        idx_next   = IDX_W'(2);
                    end else begin
                        phase_next = imu_afp_pkg::PHASE_HUNT;
                        sum_next   = '0;
                        idx_next   = '0;
                    end
                end
                imu_afp_pkg::PHASE_BODY: begin
                    if (frame_last) begin
                        yaw_out_next = {yaw_hi_reg, yaw_lo_reg};
                        ok_out_next  = (s_rx_byte == sum_reg);
                        m_valid_next = 1'b1;
                        phase_next   = imu_afp_pkg::PHASE_HUNT;
                        sum_next     = '0;
                        idx_next     = '0;
                    end else begin
                        if (idx_reg == YAW_LO) begin
                            yaw_lo_next = s_rx_byte;
                        end else if (idx_reg == YAW_HI) begin
                            yaw_hi_next = s_rx_byte;
                        end
                        sum_next = sum_reg + s_rx_byte;
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                default: begin
                    phase_next = imu_afp_pkg::PHASE_HUNT;
                    sum_next   = '0;
                    idx_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= imu_afp_pkg::PHASE_HUNT;
            idx_reg     <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        yaw_lo_reg  <= yaw_lo_next;
        yaw_hi_reg  <= yaw_hi_next;
        yaw_out_reg <= yaw_out_next;
        ok_out_reg  <= ok_out_next;
    end

    // A completed frame always leaves a result and sends the parser back to hunting.
    a_frame_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && frame_last |=> m_valid_reg && phase_reg == imu_afp_pkg::PHASE_HUNT
            && sum_reg == 8'd0)
        else $error("completed frame did not produce a result");

    // A pending result is never overwritten by the next frame.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !(s_fire && frame_last))
        else $error("pending result overwritten");

    // While collecting the body, the index stays within the frame.
    a_body_index: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == imu_afp_pkg::PHASE_BODY |-> idx_reg >= IDX_W'(2) && idx_reg <= LAST_IDX)
        else $error("body index out of range");

    // Hunting always starts from a cleared index and sum.
    a_hunt_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == imu_afp_pkg::PHASE_HUNT |-> idx_reg == '0 && sum_reg == 8'd0)
        else $error("hunt phase with stale frame state");

endmodule
